@@ rtl/core/gyi_pkg.sv @@
package gyi_pkg;

	// Default accumulator width, 2^-16 degree units
	localparam int YAW_W_DEF = 48;

	// Fixed field widths
	localparam int REQ_W   = 2;
	localparam int RAW_W   = 16;
	localparam int DT_W    = 16;
	localparam int CNT_W   = 16;
	localparam int SUM_W   = 33;
	localparam int BIAS_W  = 32;
	localparam int OUT_YAW_W = 48;
	localparam int STAT_W  = 2;

	// Shared divider sizing
	localparam int DIV_NUM_W = 48;
	localparam int DIV_DEN_W = 16;

	// Update scaling: 131 LSB per deg/s, rounding offset of half the divisor
	localparam int LSB_PER_DPS = 131;
	localparam longint UPD_DEN  = longint'(LSB_PER_DPS) * 65536;
	localparam longint UPD_HALF = UPD_DEN / 2;

	// Request kinds
	localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CALIB  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_ZERO   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_ZERO_DT = 2'd1;
	localparam logic [STAT_W-1:0] ST_ZERO_N  = 2'd2;

	// Divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ rtl/core/gyi_div.sv @@
module gyi_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [gyi_pkg::DIV_NUM_W-1:0]       dividend,
	input  logic [gyi_pkg::DIV_DEN_W-1:0]       divisor,
	output logic [gyi_pkg::DIV_NUM_W-1:0]       quotient,
	output gyi_pkg::div_stat_t                  stat
);

	localparam int NW  = gyi_pkg::DIV_NUM_W;
	localparam int DW  = gyi_pkg::DIV_DEN_W;
	localparam int SCW = $clog2(NW);

	logic [NW-1:0]  quo_q;
	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  den_q;
	logic [SCW-1:0] step_q;
	logic           busy_q;
	logic           done_q;

	// One restoring step: shift in next dividend bit, trial subtract
	logic [DW:0] trial;
	logic        fits;
	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && step_q == '0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= SCW'(NW - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DW'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[DW-1:0];
			end
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// Done pulse only ends a running division
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

endmodule

@@ rtl/core/gyro_yaw_integrator_unit.sv @@
// Flow per request: update with nonzero dt runs EVAL, MUL, PRE, DIV, APPLY and WRITE; completing
// calibration sample EVAL, CCHK, DIV, APPLY, WRITE; partial calibration sample EVAL, CCHK, WRITE; others EVAL, WRITE.
// One item at a time: the next input is taken only after the result registers and the unit returns
// to idle; the 48-step shared restoring divider dominates.
// s_tready is high only while idle; a stalled result holds the next one in its write state.
// Reset (arst_n low, asynchronous): control, yaw, bias and calibration state clear, calib_samples returns to 100.
module gyro_yaw_integrator_unit #(
	parameter int YAW_WIDTH = gyi_pkg::YAW_W_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: calib_samples
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] gyro_raw, [31:16] dt
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [47:0] yaw_angle, [79:48] bias_value
	output logic [2:0]  m_tuser    // [0] calib_done, [2:1] status
);

	localparam int NW  = gyi_pkg::DIV_NUM_W;
	localparam int DFW = 34;  // gyro*2^16 - bias
	localparam int MGW = 33;
	localparam int PW  = MGW + gyi_pkg::DT_W;

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_CCHK  = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_PRE   = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_APPLY = 3'd6;
	localparam logic [2:0] S_WRITE = 3'd7;

	logic [2:0] state_q;

	// Captured transaction
	logic [gyi_pkg::REQ_W-1:0]       req_q;
	logic signed [gyi_pkg::RAW_W-1:0] raw_q;
	logic [gyi_pkg::DT_W-1:0]        dt_q;

	// Architectural state
	logic [gyi_pkg::CNT_W-1:0]        cfg_q;
	logic signed [YAW_WIDTH-1:0]      yaw_q;
	logic signed [gyi_pkg::BIAS_W-1:0] bias_q;
	logic signed [gyi_pkg::SUM_W-1:0] sum_q;
	logic [gyi_pkg::CNT_W-1:0]        cnt_q;

	// Work registers
	logic signed [DFW-1:0]            diff_q;
	logic [PW-1:0]                    prod_q;
	logic                             neg_q;
	logic signed [31:0]               delta_q;
	logic                             done_q;
	logic [gyi_pkg::STAT_W-1:0]       stat_q;

	// Output register
	logic                             ovld_q;
	logic [79:0]                      odata_q;
	logic [2:0]                       ouser_q;

	// Shared divider hookup
	logic                 div_start;
	logic [NW-1:0]        div_num;
	logic [gyi_pkg::DIV_DEN_W-1:0] div_den;
	logic [NW-1:0]        div_quo;
	gyi_pkg::div_stat_t   div_stat;

	gyi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// Calibration finishes once collected count reaches the target
	logic cal_full;
	assign cal_full = cnt_q >= cfg_q;

	// Magnitudes for divider operands
	logic [MGW-1:0] sum_mag;
	logic [MGW-1:0] diff_mag;
	logic [PW:0]    prod_rnd;
	assign sum_mag  = sum_q[gyi_pkg::SUM_W-1] ? MGW'(-sum_q) : MGW'(sum_q);
	assign diff_mag = diff_q[DFW-1] ? MGW'(-diff_q) : diff_q[MGW-1:0];
	assign prod_rnd = (PW+1)'(prod_q) + (PW+1)'(gyi_pkg::UPD_HALF);

	// Divider operand select: calibration mean or update scaling by 131
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		if (state_q == S_CCHK) begin
			div_start = cal_full;
			div_num   = {sum_mag[31:0], 16'h0000} + NW'(cnt_q >> 1);
			div_den   = cnt_q;
		end else if (state_q == S_PRE) begin
			div_start = 1'b1;
			div_num   = NW'(prod_rnd[PW:16]);
			div_den   = gyi_pkg::DIV_DEN_W'(gyi_pkg::LSB_PER_DPS);
		end
	end

	// Signed quotient
	logic signed [31:0] quo_s;
	assign quo_s = neg_q ? -signed'(div_quo[31:0]) : signed'(div_quo[31:0]);

	// Saturating accumulate
	logic signed [YAW_WIDTH:0]   yaw_sum;
	logic signed [YAW_WIDTH-1:0] yaw_sat;
	assign yaw_sum = (YAW_WIDTH+1)'(yaw_q) + (YAW_WIDTH+1)'(delta_q);
	always_comb begin
		if (yaw_sum[YAW_WIDTH] != yaw_sum[YAW_WIDTH-1]) begin
			yaw_sat = yaw_sum[YAW_WIDTH] ? {1'b1, {(YAW_WIDTH-1){1'b0}}}
				: {1'b0, {(YAW_WIDTH-1){1'b1}}};
		end else begin
			yaw_sat = yaw_sum[YAW_WIDTH-1:0];
		end
	end

	// Output yaw: sign-extended then trimmed to the port width
	logic signed [63:0] yaw_ext;
	assign yaw_ext = 64'(yaw_q);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= gyi_pkg::CNT_W'(100);
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			yaw_q   <= '0;
			bias_q  <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			stat_q  <= gyi_pkg::ST_OK;
			ovld_q  <= 1'b0;
		end else begin
			// Result taken; the write state reloads it itself
			if (m_tready && state_q != S_WRITE) begin
				ovld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						done_q  <= 1'b0;
						stat_q  <= gyi_pkg::ST_OK;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (req_q == gyi_pkg::REQ_CALIB) begin
						if (cfg_q == '0) begin
							stat_q  <= gyi_pkg::ST_ZERO_N;
							sum_q   <= '0;
							cnt_q   <= '0;
							state_q <= S_WRITE;
						end else begin
							sum_q   <= sum_q + gyi_pkg::SUM_W'(raw_q);
							cnt_q   <= cnt_q + 1'b1;
							state_q <= S_CCHK;
						end
					end else begin
						sum_q <= '0;
						cnt_q <= '0;
						if (req_q == gyi_pkg::REQ_UPDATE) begin
							if (dt_q == '0) begin
								stat_q  <= gyi_pkg::ST_ZERO_DT;
								state_q <= S_WRITE;
							end else begin
								state_q <= S_MUL;
							end
						end else begin
							if (req_q == gyi_pkg::REQ_ZERO) begin
								yaw_q <= '0;
							end
							state_q <= S_WRITE;
						end
					end
				end
				S_CCHK: begin
					state_q <= cal_full ? S_DIV : S_WRITE;
				end
				S_MUL: begin
					state_q <= S_PRE;
				end
				S_PRE: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						if (req_q == gyi_pkg::REQ_CALIB) begin
							bias_q <= quo_s;
							sum_q  <= '0;
							cnt_q  <= '0;
							done_q <= 1'b1;
						end
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (req_q == gyi_pkg::REQ_UPDATE) begin
						yaw_q <= yaw_sat;
					end
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (!ovld_q || m_tready) begin
						ovld_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload and work registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			req_q <= s_tuser;
			raw_q <= signed'(s_tdata[15:0]);
			dt_q  <= s_tdata[31:16];
		end
		if (state_q == S_EVAL) begin
			diff_q <= DFW'(signed'({raw_q, 16'h0000})) - DFW'(bias_q);
		end
		if (state_q == S_CCHK) begin
			neg_q <= sum_q[gyi_pkg::SUM_W-1];
		end
		if (state_q == S_MUL) begin
			prod_q <= PW'(diff_mag) * PW'(dt_q);
			neg_q  <= diff_q[DFW-1];
		end
		if (state_q == S_DIV && div_stat.done) begin
			delta_q <= quo_s;
		end
		if (state_q == S_WRITE && (!ovld_q || m_tready)) begin
			odata_q <= {bias_q, yaw_ext[gyi_pkg::OUT_YAW_W-1:0]};
			ouser_q <= {stat_q, done_q};
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = ovld_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = ouser_q;

	// A completed calibration always reports accepted status
	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2:1] == gyi_pkg::ST_OK)
		else $error("calib_done with a reject status");

	// Divider is never restarted while running
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// Waiting on the divider means it is actually running
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> div_stat.busy || div_stat.done)
		else $error("sequencer waiting on an idle divider");

	// A finished calibration leaves no partial sum behind
	a_cal_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV && div_stat.done && req_q == gyi_pkg::REQ_CALIB
		|=> cnt_q == '0 && sum_q == '0)
		else $error("calibration state not cleared");

endmodule
